// ===== rtl/cws_pkg.sv =====
// cws_pkg: field widths and stream packing for the current window statistics block.
// No dependencies; used by cws_div and current_window_stats.
package cws_pkg;

  localparam int unsigned CUR_W       = 21;
  localparam int unsigned BUS_W       = 15;
  localparam int unsigned PWR_W       = 20;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned IN_FIELDS_W = CUR_W + BUS_W + PWR_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = BUS_W + PWR_W + 4 * CUR_W + CNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic signed [CUR_W-1:0] cur_t;
  typedef logic [BUS_W-1:0]        bus_t;
  typedef logic [PWR_W-1:0]        pwr_t;
  typedef logic [CNT_W-1:0]        cnt_t;

endpackage

// ===== rtl/cws_div.sv =====
// cws_div: serial signed-by-unsigned divider, one quotient bit per cycle, truncating
// toward zero. Depends on cws_pkg for the quotient width.
module cws_div #(
  parameter int unsigned SUM_W  = 25,
  parameter int unsigned FILL_W = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [FILL_W-1:0]       divisor_i,
  output logic                    busy_o,
  output cws_pkg::cur_t           quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_q;
  logic [FILL_W-1:0] rem_q;
  logic [FILL_W-1:0] div_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic              busy_q;

  logic [FILL_W:0]        shifted;
  logic                   fits;
  logic [FILL_W:0]        diff;
  logic [cws_pkg::CUR_W-1:0] mag;

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign fits    = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(SUM_W);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      busy_q <= step_q != STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      quo_q <= dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[FILL_W-1:0] : shifted[FILL_W-1:0];
    end
  end

  assign mag        = quo_q[cws_pkg::CUR_W-1:0];
  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? cws_pkg::cur_t'(~mag + 1'b1) : cws_pkg::cur_t'(mag);

endmodule

// ===== rtl/current_window_stats.sv =====
// current_window_stats: moving average, minimum, maximum and count of current samples.
// Depends on cws_pkg and cws_div.
//
// Input stream: s_axis_tuser selects the item kind (0 = sample, 1 = clear). A sample
// carries current, bus voltage and power in s_axis_tdata and yields one result item on
// the master stream; a clear item resets the statistics at accept and yields none.
// The last WINDOW currents sit in a ring memory with a registered read; the outgoing
// entry is read at accept, the sum is updated and the new entry written in the next
// cycle, then a serial divider forms the average one quotient bit per cycle.
// The sum is SUM_W = 21 + clog2(WINDOW) bits wide. A sample's result is loaded into
// the output register when the divider is done and the register is free; the next
// item is taken in the cycle after the result is loaded.
// One sample is in work at a time.
// The result sits in an output register, so a new item is accepted while it waits;
// if the receiver stalls longer, the finished average is held until the register frees.
// Reset clears the statistics; ring entries are used only after being written, so the
// memory itself needs no clearing.
module current_window_stats #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [20:0] current, [35:21] bus_millivolts, [55:36] power_milliwatts
  input  logic [cws_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] kind
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [14:0] bus_mv_out, [34:15] power_mw_out, [55:35] current_now,
  // [76:56] current_average, [97:77] current_minimum, [118:98] current_maximum,
  // [150:119] samples_seen, [151] zero
  output logic [cws_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = cws_pkg::CUR_W + $clog2(WINDOW);
  localparam int unsigned PAD_W  = cws_pkg::OUT_TDATA_W - cws_pkg::OUT_FIELDS_W;

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_DIV} state_e;

  state_e state_q;

  cws_pkg::cur_t ring_mem [WINDOW];
  cws_pkg::cur_t rd_q;

  logic [POS_W-1:0]        pos_q;
  logic [FILL_W-1:0]       fill_q;
  logic signed [SUM_W-1:0] sum_q;
  cws_pkg::cur_t           min_q;
  cws_pkg::cur_t           max_q;
  cws_pkg::cnt_t           cnt_q;

  cws_pkg::cur_t cur_q;
  cws_pkg::bus_t bus_q;
  cws_pkg::pwr_t pwr_q;

  logic                            out_valid_q;
  logic [cws_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic                    accept;
  logic                    full;
  logic signed [SUM_W-1:0] sum_d;
  logic [FILL_W-1:0]       fill_d;
  logic                    ring_wr;
  logic                    div_busy;
  cws_pkg::cur_t           avg;
  logic                    out_free;
  logic                    out_load;

  assign s_axis_tready = state_q == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = fill_q == FILL_W'(WINDOW);
  assign fill_d        = full ? fill_q : fill_q + 1'b1;
  assign sum_d         = sum_q + SUM_W'(cur_q)
                         - (full ? SUM_W'(rd_q) : SUM_W'(0));
  assign ring_wr       = state_q == ST_RD;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = (state_q == ST_DIV) && !div_busy && out_free;

  always_ff @(posedge clk_i) begin
    if (ring_wr) begin
      ring_mem[pos_q] <= cur_q;
    end
    rd_q <= ring_mem[pos_q];
  end

  cws_div #(
    .SUM_W  (SUM_W),
    .FILL_W (FILL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ring_wr),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .busy_o     (div_busy),
    .quotient_o (avg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              pos_q  <= '0;
              fill_q <= '0;
              sum_q  <= '0;
              min_q  <= '0;
              max_q  <= '0;
              cnt_q  <= '0;
            end else begin
              state_q <= ST_RD;
            end
          end
        end
        ST_RD: begin
          sum_q  <= sum_d;
          fill_q <= fill_d;
          pos_q  <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
          if (cnt_q == '0) begin
            min_q <= cur_q;
            max_q <= cur_q;
          end else begin
            if (cur_q < min_q) min_q <= cur_q;
            if (cur_q > max_q) max_q <= cur_q;
          end
          if (cnt_q != '1) begin
            cnt_q <= cnt_q + 1'b1;
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (out_load) begin
            out_data_q  <= {{PAD_W{1'b0}}, cnt_q, max_q, min_q, avg, cur_q, pwr_q, bus_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= s_axis_tdata[cws_pkg::CUR_W-1:0];
      bus_q <= s_axis_tdata[cws_pkg::CUR_W +: cws_pkg::BUS_W];
      pwr_q <= s_axis_tdata[cws_pkg::CUR_W + cws_pkg::BUS_W +: cws_pkg::PWR_W];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW))
    else $error("fill count above window size");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser |=> fill_q == '0 && cnt_q == '0 && sum_q == '0)
    else $error("clear item did not reset statistics");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> min_q <= max_q)
    else $error("minimum above maximum");

  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |=> div_busy && state_q == ST_DIV)
    else $error("divider not running after ring update");

endmodule
